FILE: sv/owbm_pkg.sv
// owbm_pkg: shared types and constants for the one-wire bus master.
// Payload structs, request codes and configuration register layout.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package owbm_pkg;

    localparam int unsigned TIME_BITS_DEFAULT = 10;
    localparam int unsigned NUM_CFG_REGS      = 7;
    localparam int unsigned CFG_ADDR_BITS     = 3;
    localparam int unsigned CFG_FIELD_MASK    = 1023;

    localparam logic [CFG_ADDR_BITS-1:0] CFG_RESET_LOW     = 3'd0;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_PRESENCE_WAIT = 3'd1;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_RESET_TAIL    = 3'd2;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_WRITE_ONE_LOW = 3'd3;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_WRITE_SLOT    = 3'd4;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_READ_LOW      = 3'd5;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_READ_TAIL     = 3'd6;

    localparam logic [9:0] CFG_DEFAULT [NUM_CFG_REGS] =
        '{10'd480, 10'd80, 10'd400, 10'd1, 10'd50, 10'd2, 10'd60};

    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_RESET = 2'd1;
    localparam logic [1:0] REQ_WRITE = 2'd2;
    localparam logic [1:0] REQ_READ  = 2'd3;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] data_byte;
        logic       line_level;
    } owbm_in_t;

    typedef struct packed {
        logic       line_drive_low;
        logic       busy_res;
        logic       done_res;
        logic       no_device;
        logic [7:0] read_data;
    } owbm_out_t;

endpackage

`default_nettype wire

FILE: sv/owbm_cfg.sv
// owbm_cfg: timing register file of the one-wire bus master.
// Seven slot-timing registers behind a plain write port.
// Depends on owbm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module owbm_cfg #(
    parameter int unsigned TIME_BITS = owbm_pkg::TIME_BITS_DEFAULT
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  cfg_wr_en,
    input  wire logic [owbm_pkg::CFG_ADDR_BITS-1:0]    cfg_addr,
    input  wire logic [TIME_BITS-1:0]                  cfg_wdata,
    output logic [owbm_pkg::NUM_CFG_REGS-1:0][TIME_BITS-1:0] cfg_regs
);

    localparam logic [TIME_BITS-1:0] VALUE_MASK = TIME_BITS'(owbm_pkg::CFG_FIELD_MASK);

    logic [owbm_pkg::NUM_CFG_REGS-1:0][TIME_BITS-1:0] regs_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < int'(owbm_pkg::NUM_CFG_REGS); i++) begin
                regs_reg[i] <= TIME_BITS'(owbm_pkg::CFG_DEFAULT[i]);
            end
        end else if (cfg_wr_en && (32'(cfg_addr) < owbm_pkg::NUM_CFG_REGS)) begin
            regs_reg[cfg_addr] <= cfg_wdata & VALUE_MASK;
        end
    end

    assign cfg_regs = regs_reg;

endmodule

`default_nettype wire

FILE: sv/owbm_core.sv
// owbm_core: slot sequencer of the one-wire bus master.
// Applies one tick or command per step and registers the result.
// Depends on owbm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module owbm_core #(
    parameter int unsigned TIME_BITS = owbm_pkg::TIME_BITS_DEFAULT
) (
    input  wire logic                                        aclk,
    input  wire logic                                        aresetn,
    input  wire logic                                        step_en,
    input  wire owbm_pkg::owbm_in_t                          item,
    input  wire logic [owbm_pkg::NUM_CFG_REGS-1:0][TIME_BITS-1:0] cfg_regs,
    output owbm_pkg::owbm_out_t                              result
);

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_RST_LOW,
        PH_RST_WAIT,
        PH_RST_TAIL,
        PH_WR_LOW,
        PH_WR_REL,
        PH_RD_LOW,
        PH_RD_SAMPLE,
        PH_RD_TAIL
    } phase_t;

    phase_t               phase_reg, phase_next;
    logic [TIME_BITS-1:0] tick_count_reg, tick_count_next;
    logic [2:0]           bit_index_reg, bit_index_next;
    logic [7:0]           shift_byte_reg, shift_byte_next;
    logic                 presence_error_reg, presence_error_next;
    logic [7:0]           last_read_reg, last_read_next;
    logic                 done_next;
    owbm_pkg::owbm_out_t  result_reg, result_next;

    logic [TIME_BITS-1:0] limit;
    logic [TIME_BITS-1:0] tick_inc;
    logic                 hit;
    logic                 wr_bit;

    assign wr_bit   = shift_byte_reg[bit_index_reg];
    assign tick_inc = tick_count_reg + TIME_BITS'(1);
    assign hit      = (tick_inc >= limit);

    always_comb begin
        unique case (phase_reg)
            PH_RST_LOW:  limit = cfg_regs[owbm_pkg::CFG_RESET_LOW];
            PH_RST_WAIT: limit = cfg_regs[owbm_pkg::CFG_PRESENCE_WAIT];
            PH_RST_TAIL: limit = cfg_regs[owbm_pkg::CFG_RESET_TAIL];
            PH_WR_LOW:   limit = wr_bit ? cfg_regs[owbm_pkg::CFG_WRITE_ONE_LOW]
                                        : cfg_regs[owbm_pkg::CFG_WRITE_SLOT];
            PH_WR_REL:   limit = cfg_regs[owbm_pkg::CFG_WRITE_SLOT];
            PH_RD_LOW:   limit = cfg_regs[owbm_pkg::CFG_READ_LOW];
            PH_RD_TAIL:  limit = cfg_regs[owbm_pkg::CFG_READ_TAIL];
            default:     limit = cfg_regs[owbm_pkg::CFG_RESET_LOW];
        endcase
    end

    always_comb begin
        phase_next          = phase_reg;
        tick_count_next     = tick_count_reg;
        bit_index_next      = bit_index_reg;
        shift_byte_next     = shift_byte_reg;
        presence_error_next = presence_error_reg;
        last_read_next      = last_read_reg;
        done_next           = 1'b0;

        if (item.req_type != owbm_pkg::REQ_TICK) begin
            if (phase_reg == PH_IDLE) begin
                tick_count_next = '0;
                bit_index_next  = '0;
                unique case (item.req_type)
                    owbm_pkg::REQ_RESET: begin
                        phase_next = PH_RST_LOW;
                    end
                    owbm_pkg::REQ_WRITE: begin
                        shift_byte_next = item.data_byte;
                        phase_next      = PH_WR_LOW;
                    end
                    default: begin
                        shift_byte_next = '0;
                        phase_next      = PH_RD_LOW;
                    end
                endcase
            end
        end else begin
            // counting phases: wrap to zero on the tick that ends the phase
            if (phase_reg != PH_IDLE && phase_reg != PH_RD_SAMPLE) begin
                tick_count_next = hit ? '0 : tick_inc;
            end
            unique case (phase_reg)
                PH_IDLE: ;
                PH_RST_LOW: begin
                    if (hit) phase_next = PH_RST_WAIT;
                end
                PH_RST_WAIT: begin
                    if (hit) begin
                        presence_error_next = item.line_level;
                        phase_next          = PH_RST_TAIL;
                    end
                end
                PH_RST_TAIL: begin
                    if (hit) begin
                        phase_next = PH_IDLE;
                        done_next  = 1'b1;
                    end
                end
                PH_WR_LOW: begin
                    if (hit) begin
                        if (wr_bit) begin
                            phase_next = PH_WR_REL;
                        end else if (bit_index_reg == 3'd7) begin
                            bit_index_next = '0;
                            phase_next     = PH_IDLE;
                            done_next      = 1'b1;
                        end else begin
                            bit_index_next = bit_index_reg + 3'd1;
                        end
                    end
                end
                PH_WR_REL: begin
                    if (hit) begin
                        if (bit_index_reg == 3'd7) begin
                            bit_index_next = '0;
                            phase_next     = PH_IDLE;
                            done_next      = 1'b1;
                        end else begin
                            bit_index_next = bit_index_reg + 3'd1;
                            phase_next     = PH_WR_LOW;
                        end
                    end
                end
                PH_RD_LOW: begin
                    if (hit) phase_next = PH_RD_SAMPLE;
                end
                PH_RD_SAMPLE: begin
                    shift_byte_next[bit_index_reg] = shift_byte_reg[bit_index_reg]
                                                     | item.line_level;
                    tick_count_next = '0;
                    phase_next      = PH_RD_TAIL;
                end
                PH_RD_TAIL: begin
                    if (hit) begin
                        if (bit_index_reg == 3'd7) begin
                            bit_index_next = '0;
                            last_read_next = shift_byte_reg;
                            phase_next     = PH_IDLE;
                            done_next      = 1'b1;
                        end else begin
                            bit_index_next = bit_index_reg + 3'd1;
                            phase_next     = PH_RD_LOW;
                        end
                    end
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase
        end

        result_next.line_drive_low = (phase_next == PH_RST_LOW) || (phase_next == PH_WR_LOW)
                                     || (phase_next == PH_RD_LOW);
        result_next.busy_res       = (phase_next != PH_IDLE);
        result_next.done_res       = done_next;
        result_next.no_device      = presence_error_next;
        result_next.read_data      = last_read_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg          <= PH_IDLE;
            tick_count_reg     <= '0;
            bit_index_reg      <= '0;
            shift_byte_reg     <= '0;
            presence_error_reg <= 1'b0;
            last_read_reg      <= '0;
        end else if (step_en) begin
            phase_reg          <= phase_next;
            tick_count_reg     <= tick_count_next;
            bit_index_reg      <= bit_index_next;
            shift_byte_reg     <= shift_byte_next;
            presence_error_reg <= presence_error_next;
            last_read_reg      <= last_read_next;
            result_reg         <= result_next;
        end
    end

    assign result = result_reg;

endmodule

`default_nettype wire

FILE: sv/one_wire_bus_master.sv
// one_wire_bus_master: top level of the one-wire bus master timing engine.
// Input register, slot sequencer, result register and handshake control.
// Depends on owbm_pkg, owbm_cfg and owbm_core.
//
// Usage:
//   s_valid/s_ready/s_data carry items: a tick (with the sampled line level)
//   or a reset, write-byte or read-byte command. All bus timing is counted in
//   tick items. m_valid/m_ready/m_data return exactly one result per item:
//   drive-low, busy, done, no-device and the last read byte.
//   Timing registers are written through cfg_wr_en/cfg_addr/cfg_wdata while
//   the block is idle; a write takes effect at the next clock edge.
// Result path: a transferred item is held in the input register, and the
//   sequencer state update then loads the result register.
// Throughput: one item per cycle while m_ready stays high; the sequencer
//   state update is the only step.
// Reset: aresetn low clears the pipeline, returns the sequencer to idle and
//   loads the default timing values.
// Stall: while m_ready is low the result register holds; one more item can
//   wait in the input register, after which s_ready drops.
`timescale 1ns / 1ps
`default_nettype none

module one_wire_bus_master #(
    parameter int unsigned TIME_BITS = owbm_pkg::TIME_BITS_DEFAULT
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 cfg_wr_en,
    input  wire logic [owbm_pkg::CFG_ADDR_BITS-1:0]   cfg_addr,
    input  wire logic [TIME_BITS-1:0]                 cfg_wdata,
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire owbm_pkg::owbm_in_t                   s_data,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output owbm_pkg::owbm_out_t                       m_data
);

    logic                 in_valid_reg;
    owbm_pkg::owbm_in_t   in_item_reg;
    logic                 out_valid_reg;
    logic                 advance;
    logic [owbm_pkg::NUM_CFG_REGS-1:0][TIME_BITS-1:0] cfg_regs;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_data;
        end
    end

    owbm_cfg #(
        .TIME_BITS (TIME_BITS)
    ) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg_regs  (cfg_regs)
    );

    owbm_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step_en  (advance),
        .item     (in_item_reg),
        .cfg_regs (cfg_regs),
        .result   (m_data)
    );

    a_advance_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid)
        else $error("result missing after state update");

    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.done_res) |-> !m_data.busy_res)
        else $error("done reported while still busy");

    a_drive_only_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.line_drive_low) |-> m_data.busy_res)
        else $error("line driven low while idle");

    a_empty_input_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_ready)
        else $error("input stalled with empty input register");

endmodule

`default_nettype wire
